>>> design/first_fit_heap_allocator_defines.svh
// Assertion macros shared by the checker of the heap allocator.
// Needs clock and reset in the scope where a macro is used.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffha check failed");

// next-cycle implication
`define FFHA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffha check failed");

`endif

>>> design/ffha_pkg.sv
// Package of the first-fit heap allocator: field widths, codes, command set.
// No dependencies.
`default_nettype none
package ffha_pkg;

   localparam int OP_W   = 2;
   localparam int REQ_W  = 21;
   localparam int ADDR_W = 32;
   localparam int ST_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam int DEF_MAX_SEGMENTS = 64;
   localparam int DEF_HEADER_BYTES = 20;
   localparam int DEF_OFFSET_BITS  = 20;

   localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = '0;
   localparam logic [REQ_W-1:0]  HEAP_BYTES_RST = 21'd1048576;

   typedef enum logic [OP_W-1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_NOSEG   = 2'd2,
      ST_NOTUSED = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAP_BASE  = 1'd0,
      CSR_HEAP_BYTES = 1'd1
   } csr_idx_type;

   // one datapath command per cycle
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_START,
      CMD_INIT,
      CMD_RD_IDX,
      CMD_FAIL,
      CMD_NEXT,
      CMD_GRANT,
      CMD_NOTUSED,
      CMD_FREE,
      CMD_SHU_RD,
      CMD_SHU_WR,
      CMD_SHU_END,
      CMD_NXT_RD,
      CMD_NXT_MERGE,
      CMD_SHD_RD,
      CMD_SHD_WR,
      CMD_SHD_END,
      CMD_PRV_RD,
      CMD_PRV_MERGE
   } dp_cmd_type;

   typedef struct packed {
      logic is_alloc;   // latched op is allocate
      logic idx_end;    // scan index reached count
      logic fits;       // read entry is free and big enough
      logic split;      // grant splits off a remainder
      logic match;      // read entry's data address equals the freed one
      logic rd_used;    // read entry is in use
      logic next_end;   // no entry after idx
      logic idx_zero;   // no entry before idx
      logic ptr_top;    // shift-up reached idx+1
      logic shd_end;    // shift-down reached the last entry
   } dp_stat_type;

endpackage
`default_nettype wire

>>> design/ffha_if.sv
// Channel interfaces of the heap allocator: request, response, register write.
// Depends on ffha_pkg.
`default_nettype none
interface ffha_req_if;
   logic                        valid;
   logic                        ready;
   logic [ffha_pkg::OP_W-1:0]   operation;
   logic [ffha_pkg::REQ_W-1:0]  request_size;
   logic [ffha_pkg::ADDR_W-1:0] free_address;
   modport source (output valid, operation, request_size, free_address, input ready);
   modport sink   (input valid, operation, request_size, free_address, output ready);
endinterface

interface ffha_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ffha_pkg::ST_W-1:0]   status;
   logic [ffha_pkg::ADDR_W-1:0] address;
   logic [ffha_pkg::REQ_W-1:0]  granted_size;
   modport source (output valid, status, address, granted_size, input ready);
   modport sink   (input valid, status, address, granted_size, output ready);
endinterface

interface ffha_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ffha_pkg::CSR_IDX_W-1:0]  index;
   logic [ffha_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/ffha_datapath.sv
// Datapath of the heap allocator: segment table memory, indexes, result word.
// Depends on ffha_pkg.
`default_nettype none
module ffha_datapath #(
   parameter int MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS,
   parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
   parameter int OFFSET_BITS  = ffha_pkg::DEF_OFFSET_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ffha_pkg::dp_cmd_type            cmd,
   output ffha_pkg::dp_stat_type                stat,
   input  wire logic                            csr_we,
   input  wire logic [ffha_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ffha_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic [ffha_pkg::OP_W-1:0]       req_operation,
   input  wire logic [ffha_pkg::REQ_W-1:0]      req_request_size,
   input  wire logic [ffha_pkg::ADDR_W-1:0]     req_free_address,
   output logic [ffha_pkg::ST_W-1:0]            rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]          rsp_address,
   output logic [ffha_pkg::REQ_W-1:0]           rsp_granted_size
);
   import ffha_pkg::*;

   localparam int OB   = OFFSET_BITS;
   localparam int IW   = $clog2(MAX_SEGMENTS);
   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int CMPW = ((OB > REQ_W) ? OB : REQ_W) + 2;
   localparam int EW   = 2 * OB + 1;
   localparam logic [CMPW-1:0] HDR_X   = CMPW'(HEADER_BYTES);
   localparam logic [CMPW-1:0] LIMIT_X = CMPW'(1) << OB;

   // entry layout: {used, size, offset}
   logic [EW-1:0] mem [MAX_SEGMENTS];
   logic          mem_we, mem_re;
   logic [IW-1:0] mem_wa, mem_ra;
   logic [EW-1:0] mem_wd;
   logic [CNTW-1:0] wsel, rsel;

   logic [ADDR_W-1:0] base_ff;
   logic [REQ_W-1:0]  hbytes_ff;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [REQ_W-1:0]  req_ff, req_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in, idx_ff, idx_in, ptr_ff, ptr_in;
   logic [OB-1:0]     cur_off_ff, cur_off_in, cur_size_ff, cur_size_in;
   logic [OB-1:0]     hold_off_ff, hold_off_in, hold_size_ff, hold_size_in;
   logic [EW-1:0]     rd_ff;
   logic [ST_W-1:0]   st_ff, st_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [REQ_W-1:0]  gsz_ff, gsz_in;

   logic              rd_used;
   logic [OB-1:0]     rd_size, rd_off, grant_size, init_size;
   logic [CMPW-1:0]   size_x, req_x, tot_x, hb_x;
   logic [ADDR_W-1:0] daddr;
   logic [CNTW:0]     idx_p1, ptr_p1;

   assign rd_used = rd_ff[EW-1];
   assign rd_size = rd_ff[2*OB-1:OB];
   assign rd_off  = rd_ff[OB-1:0];
   assign size_x  = CMPW'(rd_size);
   assign req_x   = CMPW'(req_ff);
   assign hb_x    = CMPW'(hbytes_ff);
   assign tot_x   = (hb_x > LIMIT_X) ? LIMIT_X : hb_x;
   assign init_size = (tot_x > HDR_X) ? OB'(tot_x - HDR_X) : '0;
   assign daddr   = base_ff + ADDR_W'(rd_off) + ADDR_W'(HEADER_BYTES);
   assign idx_p1  = {1'b0, idx_ff} + 1'b1;
   assign ptr_p1  = {1'b0, ptr_ff} + 1'b1;

   assign stat.is_alloc = (op_ff == OP_ALLOC);
   assign stat.idx_end  = (idx_ff >= cnt_ff);
   assign stat.fits     = !rd_used && !(size_x < req_x);
   assign stat.split    = (size_x > req_x + HDR_X + CMPW'(1))
                          && (cnt_ff < CNTW'(MAX_SEGMENTS));
   assign stat.match    = (daddr == faddr_ff);
   assign stat.rd_used  = rd_used;
   assign stat.next_end = (idx_p1 >= {1'b0, cnt_ff});
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.ptr_top  = (ptr_ff == idx_p1[CNTW-1:0]);
   assign stat.shd_end  = (ptr_p1 >= {1'b0, cnt_ff});

   assign grant_size = stat.split ? OB'(req_x) : rd_size;

   always_comb begin
      op_in = op_ff;  req_in = req_ff;  faddr_in = faddr_ff;
      cnt_in = cnt_ff;  idx_in = idx_ff;  ptr_in = ptr_ff;
      cur_off_in = cur_off_ff;  cur_size_in = cur_size_ff;
      hold_off_in = hold_off_ff;  hold_size_in = hold_size_ff;
      st_in = st_ff;  addr_in = addr_ff;  gsz_in = gsz_ff;
      mem_we = 1'b0;  mem_re = 1'b0;
      wsel = idx_ff;  rsel = idx_ff;  mem_wd = '0;
      unique case (cmd)
         CMD_START: begin
            op_in = req_operation;  req_in = req_request_size;
            faddr_in = req_free_address;  idx_in = '0;
            st_in = ST_OK;  addr_in = '0;  gsz_in = '0;
         end
         CMD_INIT: begin
            mem_we = 1'b1;  wsel = '0;
            mem_wd = {1'b0, init_size, OB'(0)};
            cnt_in = CNTW'(1);
         end
         CMD_RD_IDX: mem_re = 1'b1;
         CMD_FAIL:   st_in = stat.is_alloc ? ST_NOFIT : ST_NOSEG;
         CMD_NEXT:   idx_in = idx_ff + 1'b1;
         CMD_GRANT: begin
            mem_we = 1'b1;
            mem_wd = {1'b1, grant_size, rd_off};
            addr_in = daddr;
            gsz_in = REQ_W'(grant_size);
            hold_off_in  = OB'(CMPW'(rd_off) + HDR_X + req_x);
            hold_size_in = OB'(size_x - req_x - HDR_X);
            ptr_in = cnt_ff;
         end
         CMD_NOTUSED: st_in = ST_NOTUSED;
         CMD_FREE: begin
            mem_we = 1'b1;
            mem_wd = {1'b0, rd_size, rd_off};
            cur_off_in = rd_off;  cur_size_in = rd_size;
         end
         CMD_SHU_RD: begin
            mem_re = 1'b1;  rsel = ptr_ff - 1'b1;
         end
         CMD_SHU_WR: begin
            mem_we = 1'b1;  wsel = ptr_ff;  mem_wd = rd_ff;
            ptr_in = ptr_ff - 1'b1;
         end
         CMD_SHU_END: begin
            mem_we = 1'b1;  wsel = ptr_ff;
            mem_wd = {1'b0, hold_size_ff, hold_off_ff};
            cnt_in = cnt_ff + 1'b1;
         end
         CMD_NXT_RD: begin
            mem_re = 1'b1;  rsel = idx_p1[CNTW-1:0];
         end
         CMD_NXT_MERGE: begin
            cur_size_in = OB'(CMPW'(cur_size_ff) + HDR_X + size_x);
            mem_we = 1'b1;
            mem_wd = {1'b0, cur_size_in, cur_off_ff};
            ptr_in = idx_p1[CNTW-1:0];
         end
         CMD_SHD_RD: begin
            mem_re = 1'b1;  rsel = ptr_p1[CNTW-1:0];
         end
         CMD_SHD_WR: begin
            mem_we = 1'b1;  wsel = ptr_ff;  mem_wd = rd_ff;
            ptr_in = ptr_p1[CNTW-1:0];
         end
         CMD_SHD_END: cnt_in = cnt_ff - 1'b1;
         CMD_PRV_RD: begin
            mem_re = 1'b1;  rsel = idx_ff - 1'b1;
         end
         CMD_PRV_MERGE: begin
            mem_we = 1'b1;  wsel = idx_ff - 1'b1;
            mem_wd = {1'b0, OB'(size_x + HDR_X + CMPW'(cur_size_ff)), rd_off};
            ptr_in = idx_ff;
         end
         default: ;
      endcase
   end

   assign mem_wa = wsel[IW-1:0];
   assign mem_ra = rsel[IW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= HEAP_BASE_RST;
         hbytes_ff <= HEAP_BYTES_RST;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_we && csr_index == CSR_HEAP_BASE)  base_ff   <= csr_data;
         if (csr_we && csr_index == CSR_HEAP_BYTES) hbytes_ff <= csr_data[REQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  req_ff <= req_in;  faddr_ff <= faddr_in;
      idx_ff <= idx_in;  ptr_ff <= ptr_in;
      cur_off_ff <= cur_off_in;  cur_size_ff <= cur_size_in;
      hold_off_ff <= hold_off_in;  hold_size_ff <= hold_size_in;
      st_ff <= st_in;  addr_ff <= addr_in;  gsz_ff <= gsz_in;
   end

   assign rsp_status       = st_ff;
   assign rsp_address      = addr_ff;
   assign rsp_granted_size = gsz_ff;
endmodule
`default_nettype wire

>>> design/ffha_ctrl.sv
// Controller of the heap allocator: sequences scan, shift and merge steps.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic [ffha_pkg::OP_W-1:0] req_operation,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire ffha_pkg::dp_stat_type     stat,
   output ffha_pkg::dp_cmd_type           cmd
);
   import ffha_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_INIT = 13'b0000000000010,
      S_RD   = 13'b0000000000100,
      S_CHK  = 13'b0000000001000,
      S_SHU  = 13'b0000000010000,
      S_SHUW = 13'b0000000100000,
      S_NRD  = 13'b0000001000000,
      S_NCHK = 13'b0000010000000,
      S_SHD  = 13'b0000100000000,
      S_SHDW = 13'b0001000000000,
      S_PRD  = 13'b0010000000000,
      S_PCHK = 13'b0100000000000,
      S_RSP  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      prev_ff, prev_in;   // after removal, still try the previous entry

   always_comb begin
      state_in  = state_ff;
      prev_in   = prev_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd = CMD_START;
               unique case (req_operation) inside
                  OP_INIT:                 state_in = S_INIT;
                  OP_ALLOC, OP_FREE:       state_in = S_RD;
                  default:                 state_in = S_RSP;
               endcase
            end
         end
         S_INIT: begin
            cmd = CMD_INIT;  state_in = S_RSP;
         end
         S_RD: begin
            if (stat.idx_end) begin
               cmd = CMD_FAIL;  state_in = S_RSP;
            end else begin
               cmd = CMD_RD_IDX;  state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.is_alloc) begin
               if (stat.fits) begin
                  cmd = CMD_GRANT;
                  state_in = stat.split ? S_SHU : S_RSP;
               end else begin
                  cmd = CMD_NEXT;  state_in = S_RD;
               end
            end else if (!stat.match) begin
               cmd = CMD_NEXT;  state_in = S_RD;
            end else if (stat.rd_used) begin
               cmd = CMD_FREE;  state_in = S_NRD;
            end else begin
               cmd = CMD_NOTUSED;  state_in = S_RSP;
            end
         end
         S_SHU: begin
            if (stat.ptr_top) begin
               cmd = CMD_SHU_END;  state_in = S_RSP;
            end else begin
               cmd = CMD_SHU_RD;  state_in = S_SHUW;
            end
         end
         S_SHUW: begin
            cmd = CMD_SHU_WR;  state_in = S_SHU;
         end
         S_NRD: begin
            if (stat.next_end) state_in = S_PRD;
            else begin
               cmd = CMD_NXT_RD;  state_in = S_NCHK;
            end
         end
         S_NCHK: begin
            if (stat.rd_used) state_in = S_PRD;
            else begin
               cmd = CMD_NXT_MERGE;  prev_in = 1'b1;  state_in = S_SHD;
            end
         end
         S_SHD: begin
            if (stat.shd_end) begin
               cmd = CMD_SHD_END;
               state_in = prev_ff ? S_PRD : S_RSP;
            end else begin
               cmd = CMD_SHD_RD;  state_in = S_SHDW;
            end
         end
         S_SHDW: begin
            cmd = CMD_SHD_WR;  state_in = S_SHD;
         end
         S_PRD: begin
            if (stat.idx_zero) state_in = S_RSP;
            else begin
               cmd = CMD_PRV_RD;  state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (stat.rd_used) state_in = S_RSP;
            else begin
               cmd = CMD_PRV_MERGE;  prev_in = 1'b0;  state_in = S_SHD;
            end
         end
         S_RSP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prev_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
      end
   end
endmodule
`default_nettype wire

>>> design/first_fit_heap_allocator.sv
// First-fit heap allocator, one word in flight at a time.
// Init writes one free segment. Allocate scans entries until one fits, then on a split moves
// later entries up to make room for the remainder. Free scans for the matching entry, then
// reads up to two neighbors and moves later entries down on each merge. A new word is taken
// only after the result of the last one has been taken. Reset: table empty, heap_base 0,
// heap_bytes 1048576.
`default_nettype none
module first_fit_heap_allocator #(
   parameter int MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS,
   parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
   parameter int OFFSET_BITS  = ffha_pkg::DEF_OFFSET_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   ffha_req_if.sink  req_chan,
   ffha_rsp_if.source rsp_chan,
   ffha_csr_if.sink  csr_chan
);
   import ffha_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // registers are always writable; config must be changed only while idle, which the block does not enforce
   assign csr_chan.ready = 1'b1;

   // controller: one item in flight, result word held until taken
   ffha_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // datapath: segment table, scan/shift pointers, result registers
   ffha_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .HEADER_BYTES (HEADER_BYTES),
      .OFFSET_BITS  (OFFSET_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_we           (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .req_operation    (req_chan.operation),
      .req_request_size (req_chan.request_size),
      .req_free_address (req_chan.free_address),
      .rsp_status       (rsp_chan.status),
      .rsp_address      (rsp_chan.address),
      .rsp_granted_size (rsp_chan.granted_size)
   );
endmodule
`default_nettype wire

>>> design/ffha_checker.sv
// Port-level checks of the heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_defines.svh.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module ffha_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [ffha_pkg::ST_W-1:0]   rsp_status,
   input wire logic [ffha_pkg::ADDR_W-1:0] rsp_address,
   input wire logic [ffha_pkg::REQ_W-1:0]  rsp_granted_size
);
   import ffha_pkg::*;

   // no new word taken while a result waits
   `FFHA_ASSERT_IMP(a_busy_rsp, rsp_valid, !req_ready)
   // one item at a time
   `FFHA_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready)
   // results with a status other than OK carry zero address and size
   `FFHA_ASSERT_IMP(a_fail_zero, rsp_valid && rsp_status != ST_OK,
      rsp_address == '0 && rsp_granted_size == '0)
   `FFHA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_address) && $stable(rsp_status))
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_address      (rsp_chan.address),
   .rsp_granted_size (rsp_chan.granted_size)
);
`default_nettype wire
